FILE: rtl/iqr_pkg.sv
package iqr_pkg;

  localparam int ScoreBits = 16;
  localparam int IndexBits = 6;
  localparam int FenceBits = ScoreBits + 4;

  typedef struct packed {
    logic signed [ScoreBits-1:0] score;
    logic                        last_score;
  } iqr_req_t;

  typedef struct packed {
    logic                 keep;
    logic [IndexBits-1:0] item_index;
    logic                 last_result;
    logic                 overflow;
  } iqr_res_t;

  typedef struct packed {
    logic                        insert;
    logic                        shift;
    logic signed [ScoreBits-1:0] score;
  } iqr_cell_ctl_t;

  typedef enum logic [3:0] {
    StLoad  = 4'b0001,
    StScan  = 4'b0010,
    StFence = 4'b0100,
    StEmit  = 4'b1000
  } iqr_state_e;

endpackage

FILE: rtl/iqr_cell.sv
module iqr_cell (
  input  logic                                clk_i,
  input  iqr_pkg::iqr_cell_ctl_t              ctl_i,
  input  logic                                occupied_i,
  input  logic signed [iqr_pkg::ScoreBits-1:0] prev_val_i,
  input  logic                                prev_gt_i,
  input  logic signed [iqr_pkg::ScoreBits-1:0] next_val_i,
  output logic signed [iqr_pkg::ScoreBits-1:0] val_o,
  output logic                                gt_o
);
  import iqr_pkg::*;

  logic signed [ScoreBits-1:0] val_q;
  logic signed [ScoreBits-1:0] val_d;

  // An empty cell ranks above every score.
  assign gt_o  = !occupied_i || (val_q > ctl_i.score);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctl_i.shift) begin
      val_d = next_val_i;
    end else if (ctl_i.insert) begin
      if (prev_gt_i) begin
        val_d = prev_val_i;
      end else if (gt_o) begin
        val_d = ctl_i.score;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

FILE: rtl/iqr_sort_chain.sv
module iqr_sort_chain #(
  parameter int MAX_ITEMS = 64,
  localparam int CntW = $clog2(MAX_ITEMS + 1)
) (
  input  logic                                clk_i,
  input  iqr_pkg::iqr_cell_ctl_t              ctl_i,
  input  logic [CntW-1:0]                     count_i,
  output logic signed [iqr_pkg::ScoreBits-1:0] head_o
);
  import iqr_pkg::*;

  logic signed [ScoreBits-1:0] val [MAX_ITEMS];
  logic                        gt  [MAX_ITEMS];

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic signed [ScoreBits-1:0] prev_val;
    logic                        prev_gt;
    logic signed [ScoreBits-1:0] next_val;

    if (i == 0) begin : g_first
      assign prev_val = val[i];
      assign prev_gt  = 1'b0;
    end else begin : g_inner
      assign prev_val = val[i-1];
      assign prev_gt  = gt[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign next_val = val[i];
    end else begin : g_body
      assign next_val = val[i+1];
    end

    iqr_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl_i),
      .occupied_i (CntW'(i) < count_i),
      .prev_val_i (prev_val),
      .prev_gt_i  (prev_gt),
      .next_val_i (next_val),
      .val_o      (val[i]),
      .gt_o       (gt[i])
    );
  end

  assign head_o = val[0];

endmodule

FILE: rtl/iqr_lower_outlier_rejection.sv
// Lower outlier test by Tukey fence over a set of up to MAX_ITEMS scores.
// A request (score, last_score) is taken on a clock edge where start_i is
// high and busy_o is low. Scores load one per cycle into a store in load
// order and into a row of insertion cells that keeps them ranked; a score
// arriving when the store is full is dropped and the set is marked as
// overflowed. The request with last_score ends the set and raises busy_o.
// The ranked row then shifts toward its head to pick Q1 and Q3, the
// StFence state forms the doubled fence 5*Q1 - 3*Q3, and the StEmit
// state reads the store to give one result per score, in load order.
// busy_o stays high from the last request until the final result is on
// res_o. Results appear on res_o one per cycle, each for one cycle with
// result_valid_o high, the final one marked by last_result. The receiver
// cannot stall. Reset empties the set and drops any pending results; the
// stores themselves need no clearing.
module iqr_lower_outlier_rejection #(
  parameter int MAX_ITEMS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  iqr_pkg::iqr_req_t req_i,
  output logic              busy_o,
  output logic              result_valid_o,
  output iqr_pkg::iqr_res_t res_o
);
  import iqr_pkg::*;

  localparam int CntW = $clog2(MAX_ITEMS + 1);
  localparam int IdxW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

  iqr_state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] scan_q, scan_d;
  logic [CntW-1:0] emit_q, emit_d;
  logic            ovf_q, ovf_d;
  logic            valid_q, valid_d;
  iqr_res_t        res_q, res_d;

  logic signed [ScoreBits-1:0] q1_q, q1_d;
  logic signed [ScoreBits-1:0] q3_q, q3_d;
  logic signed [FenceBits-1:0] fence_q, fence_d;
  logic signed [ScoreBits-1:0] rd_data_q;

  logic [ScoreBits-1:0] mem [MAX_ITEMS];

  logic                        accept;
  logic                        room;
  logic                        wr_en;
  logic [IdxW-1:0]             rd_addr;
  logic [CntW+1:0]             count_x3;
  logic [CntW-1:0]             q1_idx;
  logic [CntW-1:0]             q3_idx;
  logic signed [ScoreBits-1:0] head;
  logic signed [FenceBits-1:0] q1_x, q3_x, s2_x;
  logic                        emit_last;
  iqr_cell_ctl_t               cell_ctl;

  assign busy_o = (state_q != StLoad);
  assign accept = start_i && !busy_o;
  assign room   = (count_q < CntW'(MAX_ITEMS));
  assign wr_en  = accept && room;

  assign count_x3 = {2'b00, count_q} + {1'b0, count_q, 1'b0};
  assign q1_idx   = count_q >> 2;
  assign q3_idx   = CntW'(count_x3 >> 2);

  assign q1_x = FenceBits'(q1_q);
  assign q3_x = FenceBits'(q3_q);
  assign s2_x = FenceBits'(rd_data_q) <<< 1;

  assign emit_last = ((emit_q + CntW'(1)) == count_q);
  assign rd_addr   = (state_q == StFence) ? '0 : IdxW'(emit_q + CntW'(1));

  always_comb begin
    cell_ctl.insert = wr_en;
    cell_ctl.shift  = (state_q == StScan);
    cell_ctl.score  = req_i.score;
  end

  iqr_sort_chain #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_chain (
    .clk_i   (clk_i),
    .ctl_i   (cell_ctl),
    .count_i (count_q),
    .head_o  (head)
  );

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[IdxW'(count_q)] <= req_i.score;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    scan_d  = scan_q;
    emit_d  = emit_q;
    ovf_d   = ovf_q;
    q1_d    = q1_q;
    q3_d    = q3_q;
    fence_d = fence_q;
    valid_d = 1'b0;
    res_d   = res_q;
    case (state_q)
      StLoad: begin
        if (accept) begin
          if (room) begin
            count_d = count_q + CntW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (req_i.last_score) begin
            state_d = StScan;
            scan_d  = '0;
          end
        end
      end
      StScan: begin
        if (scan_q == q1_idx) begin
          q1_d = head;
        end
        if (scan_q == q3_idx) begin
          q3_d    = head;
          state_d = StFence;
        end else begin
          scan_d = scan_q + CntW'(1);
        end
      end
      StFence: begin
        fence_d = ((q1_x <<< 2) + q1_x) - ((q3_x <<< 1) + q3_x);
        emit_d  = '0;
        state_d = StEmit;
      end
      StEmit: begin
        valid_d           = 1'b1;
        res_d.keep        = !(s2_x < fence_q);
        res_d.item_index  = IndexBits'(emit_q);
        res_d.last_result = emit_last;
        res_d.overflow    = ovf_q;
        if (emit_last) begin
          state_d = StLoad;
          count_d = '0;
          ovf_d   = 1'b0;
        end else begin
          emit_d = emit_q + CntW'(1);
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      count_q <= '0;
      scan_q  <= '0;
      emit_q  <= '0;
      ovf_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      scan_q  <= scan_d;
      emit_q  <= emit_d;
      ovf_q   <= ovf_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q1_q    <= q1_d;
    q3_q    <= q3_d;
    fence_q <= fence_d;
    res_q   <= res_d;
  end

  assign result_valid_o = valid_q;
  assign res_o          = res_q;

endmodule
